// ===== hdl/ocis_pkg.sv =====
// Shared types, codes and constants for the capture-to-record converter.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package ocis_pkg;

	// input item: begin marker or one file byte
	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
	} in_item_t;

	// result item: one record
	typedef struct packed {
		logic [1:0]  record_kind;
		logic [15:0] delay_ticks;
		logic [7:0]  reg_number;
		logic [7:0]  reg_value;
		logic [15:0] imf_length;
		logic        error_code;
		logic        multi_chip_seen;
	} out_item_t;

	// item held in the input register
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} step_t;

	// parser result for one item
	typedef struct packed {
		logic      emit;
		out_item_t item;
	} result_t;

	// parser phase, one-hot
	typedef enum logic [8:0] {
		PH_HEADER  = 9'b000000001,
		PH_CMD     = 9'b000000010,
		PH_DLY8    = 9'b000000100,
		PH_DLY16LO = 9'b000001000,
		PH_DLY16HI = 9'b000010000,
		PH_ESCREG  = 9'b000100000,
		PH_DATA    = 9'b001000000,
		PH_ENDHELD = 9'b010000000,
		PH_DONE    = 9'b100000000
	} phase_t;

	// action codes
	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_BEGIN = 1'b1;

	// record kinds
	localparam logic [1:0] KIND_PAIR  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic ERR_SIGNATURE = 1'b0;
	localparam logic ERR_VERSION   = 1'b1;

	// command codes
	localparam logic [7:0] CMD_DELAY8  = 8'h00;
	localparam logic [7:0] CMD_DELAY16 = 8'h01;
	localparam logic [7:0] CMD_CHIP_A  = 8'h02;
	localparam logic [7:0] CMD_CHIP_B  = 8'h03;
	localparam logic [7:0] CMD_ESCAPE  = 8'h04;

	// header layout (byte offsets)
	localparam logic [4:0] HDR_SIG_LAST  = 5'd7;
	localparam logic [4:0] HDR_VER_END   = 5'd12;
	localparam logic [4:0] HDR_LEN_FIRST = 5'd16;
	localparam logic [4:0] HDR_LEN_END   = 5'd20;
	localparam logic [4:0] HDR_LAST      = 5'd23;

	localparam logic [31:0] VERSION_OK = 32'h0001_0000;
	localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

	// 14/25 = 560/1000 as multiply by a reciprocal: floor(d*14/25) for any
	// 16-bit d equals (d * 14 * ceil(2^25/25)) >> 25
	localparam int          SCALE_SHIFT = 25;
	localparam logic [24:0] SCALE_MULT  = 25'd18790492;

	// signature "DBRAWOPL"
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h44;
			3'd1: b = 8'h42;
			3'd2: b = 8'h52;
			3'd3: b = 8'h41;
			3'd4: b = 8'h57;
			3'd5: b = 8'h4F;
			3'd6: b = 8'h50;
			3'd7: b = 8'h4C;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// convert a millisecond delay to 560 Hz ticks
	function automatic logic [15:0] scale_delay(input logic [15:0] d);
		logic [40:0] prod;
		prod = {25'd0, d} * {16'd0, SCALE_MULT};
		return prod[40:SCALE_SHIFT];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ocis_in_if.sv =====
// Input channel: valid/ready handshake carrying one capture byte or a begin.
// Depends on ocis_pkg for the payload type.
`default_nettype none

interface ocis_in_if;
	logic              valid;
	logic              ready;
	ocis_pkg::in_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hdl/ocis_out_if.sv =====
// Output channel: valid/ready handshake carrying one record.
// Depends on ocis_pkg for the payload type.
`default_nettype none

interface ocis_out_if;
	logic               valid;
	logic               ready;
	ocis_pkg::out_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hdl/ocis_in_reg.sv =====
// Input register: takes one item per cycle while the parser keeps stepping, and holds it until the parser steps.
// Depends on ocis_pkg and ocis_in_if.
`default_nettype none

module ocis_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ocis_in_if.sink         in_chan,
	input  wire logic       advance,
	output ocis_pkg::step_t step
);

	logic               valid_s1;
	ocis_pkg::in_item_t item_s1;

	// take a new item when empty or when the held one moves on
	assign in_chan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.ready) begin
			valid_s1 <= in_chan.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_chan.valid && in_chan.ready) begin
			item_s1 <= in_chan.item;
		end
	end

	assign step.valid = valid_s1;
	assign step.item  = item_s1;

endmodule

`default_nettype wire

// ===== hdl/ocis_parser.sv =====
// Capture parser: header check, command decode, delay scaling and records.
// Depends on ocis_pkg; steps once for each item that leaves the input register.
`default_nettype none

module ocis_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire ocis_pkg::step_t step,
	output ocis_pkg::result_t result
);

	ocis_pkg::phase_t phase_q, phase_n;
	logic [4:0]  hidx_q, hidx_n;
	logic        sig_ok_q, sig_ok_n;
	logic [31:0] version_q, version_n;
	logic [31:0] len_q, len_n;
	logic [31:0] cnt_q, cnt_n;
	logic [15:0] pend_q, pend_n;
	logic [7:0]  low_q, low_n;
	logic [7:0]  held_q, held_n;
	logic [13:0] pairs_q, pairs_n;
	logic        chip_q, chip_n;

	logic [31:0] cnt_inc;
	logic        at_end;
	logic [7:0]  b;
	logic [15:0] end_len;

	assign b       = step.item.in_byte;
	assign cnt_inc = (cnt_q == ocis_pkg::COUNT_MAX) ? cnt_q : cnt_q + 32'd1;
	assign at_end  = cnt_inc >= len_q;
	assign end_len = {pairs_q, 2'b00} + 16'd4;

	// next state and record for the held item
	always_comb begin
		phase_n   = phase_q;
		hidx_n    = hidx_q;
		sig_ok_n  = sig_ok_q;
		version_n = version_q;
		len_n     = len_q;
		cnt_n     = cnt_q;
		pend_n    = pend_q;
		low_n     = low_q;
		held_n    = held_q;
		pairs_n   = pairs_q;
		chip_n    = chip_q;

		result                      = '0;
		result.item.multi_chip_seen = chip_q;

		if (phase_q == ocis_pkg::PH_ENDHELD || step.item.action == ocis_pkg::ACT_BEGIN) begin
			// release a held end record first
			if (phase_q == ocis_pkg::PH_ENDHELD) begin
				result.emit             = 1'b1;
				result.item.record_kind = ocis_pkg::KIND_END;
				result.item.imf_length  = end_len;
				phase_n                 = ocis_pkg::PH_DONE;
			end
			// clear the parser on a begin
			if (step.item.action == ocis_pkg::ACT_BEGIN) begin
				phase_n   = ocis_pkg::PH_HEADER;
				hidx_n    = 5'd0;
				sig_ok_n  = 1'b1;
				version_n = 32'd0;
				len_n     = 32'd0;
				cnt_n     = 32'd0;
				pend_n    = 16'd0;
				low_n     = 8'd0;
				held_n    = 8'd0;
				pairs_n   = 14'd0;
				chip_n    = 1'b0;
			end
		end else begin
			unique case (phase_q)
				ocis_pkg::PH_HEADER: begin
					hidx_n = hidx_q + 5'd1;
					// collect signature, version and data length
					priority if (hidx_q <= ocis_pkg::HDR_SIG_LAST) begin
						sig_ok_n = sig_ok_q && (b == ocis_pkg::sig_byte(hidx_q[2:0]));
					end else if (hidx_q < ocis_pkg::HDR_VER_END) begin
						version_n[8*hidx_q[1:0] +: 8] = b;
					end else if (hidx_q >= ocis_pkg::HDR_LEN_FIRST &&
							hidx_q < ocis_pkg::HDR_LEN_END) begin
						len_n[8*hidx_q[1:0] +: 8] = b;
					end else begin
						hidx_n = hidx_q + 5'd1;
					end
					// verdicts at the last signature byte and the last header byte
					priority if (hidx_q == ocis_pkg::HDR_SIG_LAST && !sig_ok_n) begin
						result.emit             = 1'b1;
						result.item.record_kind = ocis_pkg::KIND_ERROR;
						result.item.error_code  = ocis_pkg::ERR_SIGNATURE;
						phase_n                 = ocis_pkg::PH_DONE;
					end else if (hidx_q >= ocis_pkg::HDR_LAST) begin
						hidx_n = hidx_q;
						priority if (version_q != ocis_pkg::VERSION_OK) begin
							result.emit             = 1'b1;
							result.item.record_kind = ocis_pkg::KIND_ERROR;
							result.item.error_code  = ocis_pkg::ERR_VERSION;
							phase_n                 = ocis_pkg::PH_DONE;
						end else if (len_q == 32'd0) begin
							result.emit             = 1'b1;
							result.item.record_kind = ocis_pkg::KIND_END;
							result.item.imf_length  = end_len;
							phase_n                 = ocis_pkg::PH_DONE;
						end else begin
							phase_n = ocis_pkg::PH_CMD;
						end
					end else begin
						phase_n = ocis_pkg::PH_HEADER;
					end
				end
				ocis_pkg::PH_CMD: begin
					cnt_n = cnt_inc;
					priority if (b == ocis_pkg::CMD_DELAY8) begin
						phase_n = ocis_pkg::PH_DLY8;
					end else if (b == ocis_pkg::CMD_DELAY16) begin
						phase_n = ocis_pkg::PH_DLY16LO;
					end else if (b == ocis_pkg::CMD_CHIP_A || b == ocis_pkg::CMD_CHIP_B) begin
						// flag a chip switch, then end if the length is used up
						chip_n = 1'b1;
						if (at_end) begin
							result.emit                 = 1'b1;
							result.item.record_kind     = ocis_pkg::KIND_END;
							result.item.imf_length      = end_len;
							result.item.multi_chip_seen = 1'b1;
							phase_n                     = ocis_pkg::PH_DONE;
						end
					end else if (b == ocis_pkg::CMD_ESCAPE) begin
						phase_n = ocis_pkg::PH_ESCREG;
					end else begin
						held_n  = b;
						phase_n = ocis_pkg::PH_DATA;
					end
				end
				ocis_pkg::PH_DLY8, ocis_pkg::PH_DLY16HI: begin
					cnt_n = cnt_inc;
					// accumulate the delay modulo 65536
					if (phase_q == ocis_pkg::PH_DLY8) begin
						pend_n = pend_q + 16'd1 + {8'd0, b};
					end else begin
						pend_n = pend_q + 16'd1 + {b, low_q};
					end
					if (at_end) begin
						result.emit             = 1'b1;
						result.item.record_kind = ocis_pkg::KIND_END;
						result.item.imf_length  = end_len;
						phase_n                 = ocis_pkg::PH_DONE;
					end else begin
						phase_n = ocis_pkg::PH_CMD;
					end
				end
				ocis_pkg::PH_DLY16LO: begin
					cnt_n   = cnt_inc;
					low_n   = b;
					phase_n = ocis_pkg::PH_DLY16HI;
				end
				ocis_pkg::PH_ESCREG: begin
					cnt_n   = cnt_inc;
					held_n  = b;
					phase_n = ocis_pkg::PH_DATA;
				end
				ocis_pkg::PH_DATA: begin
					// emit the pair and hold the end behind it if the length is used up
					cnt_n                   = cnt_inc;
					result.emit             = 1'b1;
					result.item.record_kind = ocis_pkg::KIND_PAIR;
					result.item.delay_ticks = ocis_pkg::scale_delay(pend_q);
					result.item.reg_number  = held_q;
					result.item.reg_value   = b;
					pend_n                  = 16'd0;
					pairs_n                 = pairs_q + 14'd1;
					phase_n = at_end ? ocis_pkg::PH_ENDHELD : ocis_pkg::PH_CMD;
				end
				ocis_pkg::PH_ENDHELD, ocis_pkg::PH_DONE: begin
					// drop file bytes
					phase_n = phase_q;
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	// advance the parser state once per stepped item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ocis_pkg::PH_HEADER;
			hidx_q    <= 5'd0;
			sig_ok_q  <= 1'b1;
			version_q <= 32'd0;
			len_q     <= 32'd0;
			cnt_q     <= 32'd0;
			pend_q    <= 16'd0;
			low_q     <= 8'd0;
			held_q    <= 8'd0;
			pairs_q   <= 14'd0;
			chip_q    <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_n;
			hidx_q    <= hidx_n;
			sig_ok_q  <= sig_ok_n;
			version_q <= version_n;
			len_q     <= len_n;
			cnt_q     <= cnt_n;
			pend_q    <= pend_n;
			low_q     <= low_n;
			held_q    <= held_n;
			pairs_q   <= pairs_n;
			chip_q    <= chip_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ocis_out_reg.sv =====
// Result register: holds one record on the output channel until it is taken.
// Depends on ocis_pkg and ocis_out_if.
`default_nettype none

module ocis_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ocis_out_if.source         out_chan,
	input  wire logic          advance,
	input  wire ocis_pkg::result_t result,
	output logic               free
);

	logic                valid_q;
	ocis_pkg::out_item_t item_q;

	// room for a new record when empty or when the held one is taken now
	assign free = !valid_q || out_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= result.emit;
		end else if (out_chan.ready) begin
			valid_q <= 1'b0;
		end
	end

	// load the record payload
	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			item_q <= result.item;
		end
	end

	assign out_chan.valid = valid_q;
	assign out_chan.item  = item_q;

endmodule

`default_nettype wire

// ===== hdl/opl_capture_to_imf_stream_top.sv =====
// Top level of the capture-to-record converter: input register, parser, result register.
// Depends on ocis_pkg, ocis_in_if, ocis_out_if, ocis_in_reg, ocis_parser, ocis_out_reg.
//
//   channel   | dir | payload                                   | handshake
//   ----------+-----+-------------------------------------------+-----------
//   in_chan   | in  | action, in_byte                           | valid/ready
//   out_chan  | out | record_kind, delay_ticks, reg_number,     | valid/ready
//             |     | reg_value, imf_length, error_code,        |
//             |     | multi_chip_seen                           |
//
// One item per cycle sustained while out_chan.ready stays high; after its item is
// accepted, a record passes the input register, then the parser logic into the result register.
// The parser state update is a single pass per item, so items follow back to back.
// A stalled output holds its record; one more item waits in the input register
// before in_chan.ready drops. Asynchronous reset clears all parser state at once.
`default_nettype none

module opl_capture_to_imf_stream_top (
	input wire logic   clk,
	input wire logic   arst_n,
	ocis_in_if.sink    in_chan,
	ocis_out_if.source out_chan
);

	ocis_pkg::step_t   step;
	ocis_pkg::result_t result;
	logic              out_free;
	logic              advance;

	// step the parser when an item is held and the result register has room
	assign advance = step.valid && out_free;

	ocis_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_chan (in_chan),
		.advance (advance),
		.step    (step)
	);

	ocis_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.step   (step),
		.result (result)
	);

	ocis_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.out_chan (out_chan),
		.advance  (advance),
		.result   (result),
		.free     (out_free)
	);

endmodule

`default_nettype wire

// ===== hdl/ocis_checker.sv =====
// Port-level checks of the converter's records, bound to the top level.
// Depends on ocis_pkg and the top level's channel interfaces.
`default_nettype none

module ocis_port_checks (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire ocis_pkg::out_item_t out_item
);

	// no record is offered while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("record offered during reset");

	// a stalled record holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled record changed");

	// end and error records carry no pair
	a_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.record_kind != ocis_pkg::KIND_PAIR |->
		out_item.delay_ticks == 16'd0 && out_item.reg_number == 8'd0 &&
		out_item.reg_value == 8'd0)
		else $error("pair fields set in end or error record");

	// only end records carry a length, and it is a whole number of 4-byte records
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.record_kind == ocis_pkg::KIND_END) ?
		(out_item.imf_length[1:0] == 2'b00) : (out_item.imf_length == 16'd0))
		else $error("bad output length");

	// error code only in error records, tick count within range
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.record_kind != ocis_pkg::KIND_ERROR |->
		!out_item.error_code && out_item.delay_ticks <= 16'd36699)
		else $error("error code or delay out of place");

endmodule

bind opl_capture_to_imf_stream_top ocis_port_checks u_ocis_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_chan.valid),
	.out_ready (out_chan.ready),
	.out_item  (out_chan.item)
);

`default_nettype wire
